/* sv/cfpp_pkg.sv */
`timescale 1ns / 1ps
// Shared widths, types, status codes and helpers for the cubic fit predictor.
package cfpp_pkg;

    localparam int TIME_BITS  = 16;
    localparam int VALUE_BITS = 32;
    localparam int NPTS       = 4;
    localparam int NFAC       = NPTS - 1;

    localparam int DEN_BITS  = NFAC * TIME_BITS;
    localparam int NUM_BITS  = VALUE_BITS + NFAC * TIME_BITS + 1;
    localparam int SUM_BITS  = NUM_BITS + 3;

    localparam int IN_FIELD_BITS = (NPTS + 1) * TIME_BITS + NPTS * VALUE_BITS;
    localparam int IN_DATA_BITS  = ((IN_FIELD_BITS + 7) / 8) * 8;
    localparam int OUT_DATA_BITS = ((VALUE_BITS + 7) / 8) * 8;
    localparam int STATUS_BITS   = 2;

    localparam logic [STATUS_BITS-1:0] STAT_OK        = 2'd0;
    localparam logic [STATUS_BITS-1:0] STAT_SINGULAR  = 2'd1;
    localparam logic [STATUS_BITS-1:0] STAT_SATURATED = 2'd2;

    typedef struct packed {
        logic [DEN_BITS-1:0] rem;
        logic [NUM_BITS-1:0] nq;
        logic [DEN_BITS-1:0] den;
        logic                neg;
    } lane_t;

    typedef struct packed {
        logic                  vld;
        logic                  sing;
        lane_t [NPTS-1:0]      lane;
    } div_t;

    typedef struct packed {
        logic                 neg;
        logic [TIME_BITS-1:0] mag;
    } tdiff_t;

    function automatic tdiff_t time_diff(input logic [TIME_BITS-1:0] a,
                                         input logic [TIME_BITS-1:0] b);
        logic [TIME_BITS:0] d;
        tdiff_t r;
        d = {1'b0, a} - {1'b0, b};
        r.neg = d[TIME_BITS];
        r.mag = d[TIME_BITS] ? (b - a) : d[TIME_BITS-1:0];
        return r;
    endfunction

endpackage

/* sv/cubic_fit_position_predictor.sv */
`timescale 1ns / 1ps
// Pipeline: front stages, a row of divider cells and back stages lie between input
//   transfer and result; the divider cell row makes up most of that.
// Throughput: one item per cycle; the whole pipeline holds only while the output
//   register is full and not taken.
// Reset: asynchronous, active low; clears the valid bits, no clearing pass.
module cubic_fit_position_predictor
    import cfpp_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    // time_0, time_1, time_2, time_3, value_0, value_1, value_2, value_3, target_time
    input  logic [IN_DATA_BITS-1:0]   s_tdata,
    output logic                      m_tvalid,
    input  logic                      m_tready,
    // estimate
    output logic [OUT_DATA_BITS-1:0]  m_tdata,
    // status
    output logic [STATUS_BITS-1:0]    m_tuser
);

    logic                             en;
    logic [NPTS-1:0][TIME_BITS-1:0]   t;
    logic [NPTS-1:0][VALUE_BITS-1:0]  v;
    logic [TIME_BITS-1:0]             tgt;
    logic [VALUE_BITS-1:0]            estimate;
    div_t                             chain [NUM_BITS+1];

    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    always_comb
    begin
        for (int i = 0; i < NPTS; i++)
        begin
            t[i] = s_tdata[i*TIME_BITS +: TIME_BITS];
            v[i] = s_tdata[NPTS*TIME_BITS + i*VALUE_BITS +: VALUE_BITS];
        end
        tgt = s_tdata[NPTS*TIME_BITS + NPTS*VALUE_BITS +: TIME_BITS];
    end

    cfpp_front u_front
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .en     (en),
        .in_vld (s_tvalid),
        .t      (t),
        .v      (v),
        .tgt    (tgt),
        .d_out  (chain[0])
    );

    for (genvar k = 0; k < NUM_BITS; k++)
    begin : g_cell
        cfpp_div_cell u_cell
        (
            .clk   (clk),
            .rst_n (rst_n),
            .en    (en),
            .d_in  (chain[k]),
            .d_out (chain[k+1])
        );
    end

    cfpp_back u_back
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .d_in     (chain[NUM_BITS]),
        .out_vld  (m_tvalid),
        .estimate (estimate),
        .status   (m_tuser)
    );

    assign m_tdata = OUT_DATA_BITS'(estimate);

    a_singular_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == STAT_SINGULAR) |-> (estimate == '0))
        else $error("singular result carries nonzero estimate");

    a_sat_bound: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == STAT_SATURATED) |->
            (estimate == {1'b1, {(VALUE_BITS-1){1'b0}}}) ||
            (estimate == {1'b0, {(VALUE_BITS-1){1'b1}}}))
        else $error("saturated estimate is not a range bound");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tuser == STAT_OK) || (m_tuser == STAT_SINGULAR) ||
                     (m_tuser == STAT_SATURATED))
        else $error("undefined status code");

endmodule

/* sv/cfpp_front.sv */
`timescale 1ns / 1ps
// Front pipeline: time differences and products forming Lagrange numerators and denominators.
module cfpp_front
    import cfpp_pkg::*;
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  en,
    input  logic                                  in_vld,
    input  logic [NPTS-1:0][TIME_BITS-1:0]        t,
    input  logic [NPTS-1:0][VALUE_BITS-1:0]       v,
    input  logic [TIME_BITS-1:0]                  tgt,
    output div_t                                  d_out
);

    localparam int NB1 = VALUE_BITS + TIME_BITS;
    localparam int NB2 = VALUE_BITS + 2 * TIME_BITS;
    localparam int NB3 = VALUE_BITS + 3 * TIME_BITS;
    localparam int DB2 = 2 * TIME_BITS;

    logic [4:0] vld_reg, vld_next;
    logic [4:0] sing_reg, sing_next;

    logic [NPTS-1:0][NFAC-1:0][TIME_BITS-1:0] a_dn_reg, a_dn_next;
    logic [NPTS-1:0][NFAC-1:0][TIME_BITS-1:0] a_dd_reg, a_dd_next;
    logic [NPTS-1:0]                          a_neg_reg, a_neg_next;
    logic [NPTS-1:0][VALUE_BITS-1:0]          a_mag_reg, a_mag_next;

    logic [NPTS-1:0][NB1-1:0]                 b_num_reg, b_num_next;
    logic [NPTS-1:0][DB2-1:0]                 b_den_reg, b_den_next;
    logic [NPTS-1:0][1:0][TIME_BITS-1:0]      b_dn_reg, b_dn_next;
    logic [NPTS-1:0][TIME_BITS-1:0]           b_dd_reg, b_dd_next;
    logic [NPTS-1:0]                          b_neg_reg, b_neg_next;

    logic [NPTS-1:0][NB2-1:0]                 c_num_reg, c_num_next;
    logic [NPTS-1:0][DEN_BITS-1:0]            c_den_reg, c_den_next;
    logic [NPTS-1:0][TIME_BITS-1:0]           c_dn_reg, c_dn_next;
    logic [NPTS-1:0]                          c_neg_reg, c_neg_next;

    logic [NPTS-1:0][NB3-1:0]                 d_num_reg, d_num_next;
    logic [NPTS-1:0][DEN_BITS-1:0]            d_den_reg, d_den_next;
    logic [NPTS-1:0]                          d_neg_reg, d_neg_next;

    div_t e_reg, e_next;

    always_comb
    begin
        tdiff_t fd;
        int     j;
        logic   sg;
        logic   sing;
        sing = 1'b0;
        for (int i = 0; i < NPTS; i++)
        begin
            for (int k = i + 1; k < NPTS; k++)
            begin
                if (t[i] == t[k])
                begin
                    sing = 1'b1;
                end
            end
        end
        for (int i = 0; i < NPTS; i++)
        begin
            sg = v[i][VALUE_BITS-1];
            a_mag_next[i] = sg ? (~v[i] + 1'b1) : v[i];
            for (int k = 0; k < NFAC; k++)
            begin
                j = (k < i) ? k : k + 1;
                fd = time_diff(tgt, t[j]);
                a_dn_next[i][k] = fd.mag;
                sg = sg ^ fd.neg;
                fd = time_diff(t[i], t[j]);
                a_dd_next[i][k] = fd.mag;
                sg = sg ^ fd.neg;
            end
            a_neg_next[i] = sg;
        end
        vld_next  = {vld_reg[3:0], in_vld};
        sing_next = {sing_reg[3:0], sing};
    end

    always_comb
    begin
        for (int i = 0; i < NPTS; i++)
        begin
            b_num_next[i] = NB1'(a_mag_reg[i]) * NB1'(a_dn_reg[i][0]);
            b_den_next[i] = DB2'(a_dd_reg[i][0]) * DB2'(a_dd_reg[i][1]);
            b_dn_next[i]  = {a_dn_reg[i][2], a_dn_reg[i][1]};
            b_dd_next[i]  = a_dd_reg[i][2];
            b_neg_next[i] = a_neg_reg[i];

            c_num_next[i] = NB2'(b_num_reg[i]) * NB2'(b_dn_reg[i][0]);
            c_den_next[i] = DEN_BITS'(b_den_reg[i]) * DEN_BITS'(b_dd_reg[i]);
            c_dn_next[i]  = b_dn_reg[i][1];
            c_neg_next[i] = b_neg_reg[i];

            d_num_next[i] = NB3'(c_num_reg[i]) * NB3'(c_dn_reg[i]);
            d_den_next[i] = c_den_reg[i];
            d_neg_next[i] = c_neg_reg[i];

            e_next.lane[i].rem = '0;
            e_next.lane[i].nq  = NUM_BITS'(d_num_reg[i])
                               + NUM_BITS'(d_den_reg[i] >> 1);
            e_next.lane[i].den = d_den_reg[i];
            e_next.lane[i].neg = d_neg_reg[i];
        end
        e_next.vld  = vld_reg[3];
        e_next.sing = sing_reg[3];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sing_reg  <= sing_next;
            a_dn_reg  <= a_dn_next;
            a_dd_reg  <= a_dd_next;
            a_neg_reg <= a_neg_next;
            a_mag_reg <= a_mag_next;
            b_num_reg <= b_num_next;
            b_den_reg <= b_den_next;
            b_dn_reg  <= b_dn_next;
            b_dd_reg  <= b_dd_next;
            b_neg_reg <= b_neg_next;
            c_num_reg <= c_num_next;
            c_den_reg <= c_den_next;
            c_dn_reg  <= c_dn_next;
            c_neg_reg <= c_neg_next;
            d_num_reg <= d_num_next;
            d_den_reg <= d_den_next;
            d_neg_reg <= d_neg_next;
            e_reg     <= e_next;
        end
    end

    always_comb
    begin
        d_out     = e_reg;
        d_out.vld = vld_reg[4];
    end

endmodule

/* sv/cfpp_div_cell.sv */
`timescale 1ns / 1ps
// Divider cell: one restoring quotient bit for every lane, handed to the next cell.
module cfpp_div_cell
    import cfpp_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic en,
    input  div_t d_in,
    output div_t d_out
);

    logic vld_reg;
    div_t pay_reg, pay_next;
    logic [NPTS-1:0][DEN_BITS:0] trial;
    logic [NPTS-1:0][DEN_BITS:0] diff;
    logic [NPTS-1:0]             ge;

    always_comb
    begin
        pay_next = d_in;
        for (int i = 0; i < NPTS; i++)
        begin
            trial[i] = {d_in.lane[i].rem, d_in.lane[i].nq[NUM_BITS-1]};
            diff[i]  = trial[i] - {1'b0, d_in.lane[i].den};
            ge[i]    = trial[i] >= {1'b0, d_in.lane[i].den};
            pay_next.lane[i].rem = ge[i] ? diff[i][DEN_BITS-1:0]
                                         : trial[i][DEN_BITS-1:0];
            pay_next.lane[i].nq  = {d_in.lane[i].nq[NUM_BITS-2:0], ge[i]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg <= d_in.vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pay_reg <= pay_next;
        end
    end

    always_comb
    begin
        d_out     = pay_reg;
        d_out.vld = vld_reg;
    end

endmodule

/* sv/cfpp_back.sv */
`timescale 1ns / 1ps
// Back pipeline: sign the quotients, sum the terms, saturate (or zero a singular result) into the output register.
module cfpp_back
    import cfpp_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    en,
    input  div_t                    d_in,
    output logic                    out_vld,
    output logic [VALUE_BITS-1:0]   estimate,
    output logic [STATUS_BITS-1:0]  status
);

    logic [3:0] vld_reg, vld_next;
    logic [2:0] sing_reg, sing_next;

    logic signed [NPTS-1:0][SUM_BITS-1:0] term_reg, term_next;
    logic signed [1:0][SUM_BITS-1:0]      pair_reg, pair_next;
    logic signed [SUM_BITS-1:0]           sum_reg, sum_next;
    logic [VALUE_BITS-1:0]                est_reg, est_next;
    logic [STATUS_BITS-1:0]               stat_reg, stat_next;

    logic [SUM_BITS-VALUE_BITS:0]         upper;
    logic                                 fits;

    always_comb
    begin
        for (int i = 0; i < NPTS; i++)
        begin
            term_next[i] = d_in.lane[i].neg ? -SUM_BITS'(d_in.lane[i].nq)
                                            : SUM_BITS'(d_in.lane[i].nq);
        end
        pair_next[0] = term_reg[0] + term_reg[1];
        pair_next[1] = term_reg[2] + term_reg[3];
        sum_next     = pair_reg[0] + pair_reg[1];

        upper = sum_reg[SUM_BITS-1:VALUE_BITS-1];
        fits  = (&upper) || !(|upper);
        if (sing_reg[2])
        begin
            est_next  = '0;
            stat_next = STAT_SINGULAR;
        end
        else if (fits)
        begin
            est_next  = sum_reg[VALUE_BITS-1:0];
            stat_next = STAT_OK;
        end
        else
        begin
            est_next  = sum_reg[SUM_BITS-1] ? {1'b1, {(VALUE_BITS-1){1'b0}}}
                                            : {1'b0, {(VALUE_BITS-1){1'b1}}};
            stat_next = STAT_SATURATED;
        end
        vld_next  = {vld_reg[2:0], d_in.vld};
        sing_next = {sing_reg[1:0], d_in.sing};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sing_reg <= sing_next;
            term_reg <= term_next;
            pair_reg <= pair_next;
            sum_reg  <= sum_next;
            est_reg  <= est_next;
            stat_reg <= stat_next;
        end
    end

    assign out_vld  = vld_reg[3];
    assign estimate = est_reg;
    assign status   = stat_reg;

endmodule
